// File: design/psju_pkg.sv
// Shared types, codes and constants of the skip, jump and compare unit.
`default_nettype none
package psju_pkg;

  localparam int unsigned WordW = 36;
  localparam int unsigned AddrW = 18;

  // Instruction class codes (opcode bits 5:3).
  localparam logic [2:0] MODE_CAI  = 3'd0;
  localparam logic [2:0] MODE_CAM  = 3'd1;
  localparam logic [2:0] MODE_JUMP = 3'd2;
  localparam logic [2:0] MODE_SKIP = 3'd3;
  localparam logic [2:0] MODE_AOJ  = 3'd4;
  localparam logic [2:0] MODE_AOS  = 3'd5;
  localparam logic [2:0] MODE_SOJ  = 3'd6;
  localparam logic [2:0] MODE_SOS  = 3'd7;

  // Condition codes (opcode bits 2:0).
  localparam logic [2:0] COND_NEVER  = 3'd0;
  localparam logic [2:0] COND_L      = 3'd1;
  localparam logic [2:0] COND_E      = 3'd2;
  localparam logic [2:0] COND_LE     = 3'd3;
  localparam logic [2:0] COND_ALWAYS = 3'd4;
  localparam logic [2:0] COND_GE     = 3'd5;
  localparam logic [2:0] COND_N      = 3'd6;
  localparam logic [2:0] COND_G      = 3'd7;

  // Program counter actions.
  localparam logic [1:0] PC_NONE = 2'd0;
  localparam logic [1:0] PC_JUMP = 2'd1;
  localparam logic [1:0] PC_SKIP = 2'd2;

  // Flag bit positions.
  localparam int unsigned FlagOvf  = 0;
  localparam int unsigned FlagCry0 = 1;
  localparam int unsigned FlagCry1 = 2;
  localparam int unsigned FlagTrp1 = 3;

  localparam logic [WordW-1:0] WordMaxPos = 36'o377777777777;
  localparam logic [WordW-1:0] WordSign   = 36'o400000000000;
  localparam logic [WordW-1:0] WordOnes   = 36'o777777777777;

  typedef struct packed {
    logic [2:0]       mode;
    logic [2:0]       condition;
    logic [3:0]       ac_number;
    logic [WordW-1:0] ac_word;
    logic [WordW-1:0] mem_word;
    logic [AddrW-1:0] eff_addr;
    logic [AddrW-1:0] prog_counter;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic             write_ac;
    logic             write_mem;
    logic [1:0]       pc_action;
    logic [AddrW-1:0] next_pc;
    logic [3:0]       flags_set;
  } out_item_t;

  // After the arithmetic stage: operands ready for the compare.
  typedef struct packed {
    logic [2:0]       condition;
    logic             is_jump;
    logic             write_ac;
    logic             write_mem;
    logic [WordW-1:0] result_word;
    logic [WordW-1:0] lhs;
    logic [WordW-1:0] rhs;
    logic [AddrW-1:0] eff_addr;
    logic [AddrW-1:0] skip_pc;
    logic [3:0]       flags_set;
  } arith_t;

  // After the compare stage: relation bits in place of the operands.
  typedef struct packed {
    logic [2:0]       condition;
    logic             is_jump;
    logic             write_ac;
    logic             write_mem;
    logic [WordW-1:0] result_word;
    logic             less;
    logic             equal;
    logic [AddrW-1:0] eff_addr;
    logic [AddrW-1:0] skip_pc;
    logic [3:0]       flags_set;
  } cmp_t;

endpackage
`default_nettype wire

// File: design/pdp10_skip_jump_unit.sv
// Top level of the skip, jump and compare execution unit.
// Items pass the arith and cmp registers to the output register. Throughput: one item per
// cycle unless the output stalls; the stages are the 36-bit add, the 36-bit compare and the
// condition and PC select. Each stage stalls only when it holds an item that cannot move.
// Reset clears the stage valid bits asynchronously; the payload registers are not reset.
`default_nettype none
module pdp10_skip_jump_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire psju_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output psju_pkg::out_item_t    out_item_o
);

  // Every stage register has its own valid bit, so a bubble inside the pipe is
  // squeezed out while the output is stalled: a stage holds only when it is
  // full and the stage after it holds too.
  logic              arith_valid, arith_stall;
  psju_pkg::arith_t  arith_item;
  logic              cmp_valid, cmp_stall;
  psju_pkg::cmp_t    cmp_item;

  // Stage one decodes the class, runs the shared +1/-1 adder, derives the
  // flags and picks the operand pair that the compare will use.
  psju_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item_i),
    .valid_o (arith_valid),
    .stall_i (arith_stall),
    .item_o  (arith_item)
  );

  // Stage two reduces the two 36-bit operands to less-than and equal bits.
  psju_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (arith_valid),
    .stall_o (arith_stall),
    .item_i  (arith_item),
    .valid_o (cmp_valid),
    .stall_i (cmp_stall),
    .item_o  (cmp_item)
  );

  // Stage three tests the condition and chooses between jump to E and skip
  // to PC+2; its register is the output register of the unit.
  psju_resolve u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmp_valid),
    .stall_o (cmp_stall),
    .item_i  (cmp_item),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item_o)
  );

  // Memory-updating classes never jump.
  a_mem_no_jump : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_mem |-> out_item_o.pc_action != psju_pkg::PC_JUMP)
    else $error("memory write paired with a jump");

  // With no PC change the new PC field reads zero.
  a_idle_pc_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.pc_action == psju_pkg::PC_NONE) |-> out_item_o.next_pc == '0)
    else $error("next PC set without a PC action");

  // Overflow always comes with trap one.
  a_ovf_trap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.flags_set[psju_pkg::FlagOvf]
      |-> out_item_o.flags_set[psju_pkg::FlagTrp1])
    else $error("overflow without trap one");

  // A full output stage that is stalled backs the stall up to the input
  // only when the middle stages are full as well.
  a_stall_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> arith_valid && cmp_valid && out_valid_o && out_stall_i)
    else $error("input stalled while the pipe had room");

endmodule
`default_nettype wire

// File: design/psju_arith.sv
// First stage: class decode, increment or decrement, flags and operand select.
`default_nettype none
module psju_arith (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire psju_pkg::in_item_t item_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output psju_pkg::arith_t       item_o
);

  logic              valid_q;
  psju_pkg::arith_t  data_d, data_q;
  logic              is_dec;
  logic              use_mem;
  logic [psju_pkg::WordW-1:0] src;
  logic [psju_pkg::WordW-1:0] sum;
  logic [3:0]        flags;

  assign is_dec  = (item_i.mode == psju_pkg::MODE_SOJ) || (item_i.mode == psju_pkg::MODE_SOS);
  assign use_mem = (item_i.mode == psju_pkg::MODE_AOS) || (item_i.mode == psju_pkg::MODE_SOS);
  assign src     = use_mem ? item_i.mem_word : item_i.ac_word;
  assign sum     = src + (is_dec ? psju_pkg::WordOnes : psju_pkg::WordW'(1));

  always_comb begin
    flags = 4'b0000;
    if (is_dec) begin
      if (src == psju_pkg::WordSign) begin
        flags[psju_pkg::FlagOvf]  = 1'b1;
        flags[psju_pkg::FlagCry0] = 1'b1;
        flags[psju_pkg::FlagTrp1] = 1'b1;
      end else if (src != '0) begin
        flags[psju_pkg::FlagCry0] = 1'b1;
        flags[psju_pkg::FlagCry1] = 1'b1;
      end
    end else begin
      if (src == psju_pkg::WordMaxPos) begin
        flags[psju_pkg::FlagOvf]  = 1'b1;
        flags[psju_pkg::FlagCry1] = 1'b1;
        flags[psju_pkg::FlagTrp1] = 1'b1;
      end else if (src == psju_pkg::WordOnes) begin
        flags[psju_pkg::FlagCry0] = 1'b1;
        flags[psju_pkg::FlagCry1] = 1'b1;
      end
    end
  end

  always_comb begin
    data_d             = '0;
    data_d.condition   = item_i.condition;
    data_d.eff_addr    = item_i.eff_addr;
    data_d.skip_pc     = item_i.prog_counter + psju_pkg::AddrW'(2);
    case (item_i.mode)
      psju_pkg::MODE_CAI: begin
        data_d.lhs = item_i.ac_word;
        data_d.rhs = {{(psju_pkg::WordW - psju_pkg::AddrW){1'b0}}, item_i.eff_addr};
      end
      psju_pkg::MODE_CAM: begin
        data_d.lhs = item_i.ac_word;
        data_d.rhs = item_i.mem_word;
      end
      psju_pkg::MODE_JUMP: begin
        data_d.lhs     = item_i.ac_word;
        data_d.is_jump = 1'b1;
      end
      psju_pkg::MODE_SKIP: begin
        data_d.result_word = item_i.mem_word;
        data_d.lhs         = item_i.mem_word;
        data_d.write_ac    = item_i.ac_number != '0;
      end
      psju_pkg::MODE_AOJ, psju_pkg::MODE_SOJ: begin
        data_d.result_word = sum;
        data_d.lhs         = sum;
        data_d.write_ac    = 1'b1;
        data_d.is_jump     = 1'b1;
        data_d.flags_set   = flags;
      end
      default: begin
        // AOS and SOS update memory and optionally copy to the AC.
        data_d.result_word = sum;
        data_d.lhs         = sum;
        data_d.write_mem   = 1'b1;
        data_d.write_ac    = item_i.ac_number != '0;
        data_d.flags_set   = flags;
      end
    endcase
  end

  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = data_q;

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> valid_o)
    else $error("accepted item did not reach the arithmetic register");

endmodule
`default_nettype wire

// File: design/psju_cmp.sv
// Second stage: signed 36-bit compare of the selected operands.
`default_nettype none
module psju_cmp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire psju_pkg::arith_t  item_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output psju_pkg::cmp_t         item_o
);

  logic            valid_q;
  psju_pkg::cmp_t  data_d, data_q;

  always_comb begin
    data_d.condition   = item_i.condition;
    data_d.is_jump     = item_i.is_jump;
    data_d.write_ac    = item_i.write_ac;
    data_d.write_mem   = item_i.write_mem;
    data_d.result_word = item_i.result_word;
    data_d.less        = $signed(item_i.lhs) < $signed(item_i.rhs);
    data_d.equal       = item_i.lhs == item_i.rhs;
    data_d.eff_addr    = item_i.eff_addr;
    data_d.skip_pc     = item_i.skip_pc;
    data_d.flags_set   = item_i.flags_set;
  end

  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = data_q;

endmodule
`default_nettype wire

// File: design/psju_resolve.sv
// Third stage: condition test and program counter decision, output register.
`default_nettype none
module psju_resolve (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire psju_pkg::cmp_t    item_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output psju_pkg::out_item_t    item_o
);

  logic                 valid_q;
  psju_pkg::out_item_t  data_d, data_q;
  logic                 taken;

  always_comb begin
    case (item_i.condition)
      psju_pkg::COND_L:      taken = item_i.less;
      psju_pkg::COND_E:      taken = item_i.equal;
      psju_pkg::COND_LE:     taken = item_i.less | item_i.equal;
      psju_pkg::COND_ALWAYS: taken = 1'b1;
      psju_pkg::COND_GE:     taken = ~item_i.less;
      psju_pkg::COND_N:      taken = ~item_i.equal;
      psju_pkg::COND_G:      taken = ~(item_i.less | item_i.equal);
      default:               taken = 1'b0;
    endcase
  end

  always_comb begin
    data_d.result_word = item_i.result_word;
    data_d.write_ac    = item_i.write_ac;
    data_d.write_mem   = item_i.write_mem;
    data_d.flags_set   = item_i.flags_set;
    data_d.pc_action   = psju_pkg::PC_NONE;
    data_d.next_pc     = '0;
    if (taken) begin
      if (item_i.is_jump) begin
        data_d.pc_action = psju_pkg::PC_JUMP;
        data_d.next_pc   = item_i.eff_addr;
      end else begin
        data_d.pc_action = psju_pkg::PC_SKIP;
        data_d.next_pc   = item_i.skip_pc;
      end
    end
  end

  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = data_q;

endmodule
`default_nettype wire

// File: bench/pdp10_skip_jump_unit_test.sv
// Self-checking bench for the skip, jump and compare unit, with random stalls on both sides.
`timescale 1ns / 100ps
module pdp10_skip_jump_unit_test;
  import psju_pkg::*;

  // The run is stopped here if the results stop coming. Even with both sides
  // idling heavily and the long receiver hold, the slowest correct run ends
  // long before this limit.
  localparam int CycleLimit = 200000;
  localparam int RandomInstrs = 1700;
  // Receiver hold-off used to fill the pipeline and force an input stall.
  localparam int HoldCycles = 80;
  localparam int HoldStartAt = 300;
  // Window of accepted items in which neither side idles.
  localparam int SteadyFrom = 700;
  localparam int SteadyTo = 1000;
  localparam int IdlePercent = 36;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Instructions waiting to be issued, and the outcomes the unit owes us,
  // oldest first.
  in_item_t instr_q[$];
  out_item_t outcome_q[$];

  int issued_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic steady;

  pdp10_skip_jump_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Flags of an add-one on a 36-bit word. Only the two boundary values set any.
  function automatic logic [3:0] add_one_flags(logic [WordW-1:0] old);
    logic [3:0] f;
    f = '0;
    if (old == WordMaxPos) begin
      f[FlagOvf] = 1'b1;
      f[FlagCry1] = 1'b1;
      f[FlagTrp1] = 1'b1;
    end else if (old == WordOnes) begin
      f[FlagCry0] = 1'b1;
      f[FlagCry1] = 1'b1;
    end
    return f;
  endfunction

  // Flags of a subtract-one. The most negative word overflows, any other
  // nonzero word carries out of both bits, and zero sets nothing.
  function automatic logic [3:0] sub_one_flags(logic [WordW-1:0] old);
    logic [3:0] f;
    f = '0;
    if (old == WordSign) begin
      f[FlagOvf] = 1'b1;
      f[FlagCry0] = 1'b1;
      f[FlagTrp1] = 1'b1;
    end else if (old != '0) begin
      f[FlagCry0] = 1'b1;
      f[FlagCry1] = 1'b1;
    end
    return f;
  endfunction

  // Works out what the unit must return for one instruction.
  function automatic out_item_t execute_instr(in_item_t ins);
    out_item_t o;
    logic [WordW-1:0] lhs;
    logic [WordW-1:0] rhs;
    logic is_jump;
    logic taken;
    o = '0;
    lhs = '0;
    rhs = '0;
    is_jump = 1'b0;
    taken = 1'b0;
    case (ins.mode)
      MODE_CAI: begin
        // The immediate is the address, zero-extended: never negative.
        lhs = ins.ac_word;
        rhs = {{(WordW - AddrW){1'b0}}, ins.eff_addr};
      end
      MODE_CAM: begin
        lhs = ins.ac_word;
        rhs = ins.mem_word;
      end
      MODE_JUMP: begin
        lhs = ins.ac_word;
        is_jump = 1'b1;
      end
      MODE_SKIP: begin
        o.result_word = ins.mem_word;
        lhs = ins.mem_word;
        o.write_ac = |ins.ac_number;
      end
      MODE_AOJ: begin
        o.result_word = ins.ac_word + 1'b1;
        o.flags_set = add_one_flags(ins.ac_word);
        lhs = o.result_word;
        o.write_ac = 1'b1;
        is_jump = 1'b1;
      end
      MODE_AOS: begin
        o.result_word = ins.mem_word + 1'b1;
        o.flags_set = add_one_flags(ins.mem_word);
        lhs = o.result_word;
        o.write_mem = 1'b1;
        o.write_ac = |ins.ac_number;
      end
      MODE_SOJ: begin
        o.result_word = ins.ac_word - 1'b1;
        o.flags_set = sub_one_flags(ins.ac_word);
        lhs = o.result_word;
        o.write_ac = 1'b1;
        is_jump = 1'b1;
      end
      default: begin
        o.result_word = ins.mem_word - 1'b1;
        o.flags_set = sub_one_flags(ins.mem_word);
        lhs = o.result_word;
        o.write_mem = 1'b1;
        o.write_ac = |ins.ac_number;
      end
    endcase
    // Every class compares as signed 36-bit; the classes without a second
    // operand compare against zero.
    case (ins.condition)
      COND_NEVER:  taken = 1'b0;
      COND_L:      taken = $signed(lhs) < $signed(rhs);
      COND_E:      taken = lhs == rhs;
      COND_LE:     taken = $signed(lhs) <= $signed(rhs);
      COND_ALWAYS: taken = 1'b1;
      COND_GE:     taken = $signed(lhs) >= $signed(rhs);
      COND_N:      taken = lhs != rhs;
      default:     taken = $signed(lhs) > $signed(rhs);
    endcase
    if (taken) begin
      if (is_jump) begin
        o.pc_action = PC_JUMP;
        o.next_pc = ins.eff_addr;
      end else begin
        o.pc_action = PC_SKIP;
        o.next_pc = ins.prog_counter + 2'd2;
      end
    end
    return o;
  endfunction

  task automatic queue_instr(logic [2:0] mode, logic [2:0] cond, logic [3:0] acn,
                             logic [WordW-1:0] acw, logic [WordW-1:0] memw,
                             logic [AddrW-1:0] ea, logic [AddrW-1:0] pc);
    in_item_t ins;
    ins.mode = mode;
    ins.condition = cond;
    ins.ac_number = acn;
    ins.ac_word = acw;
    ins.mem_word = memw;
    ins.eff_addr = ea;
    ins.prog_counter = pc;
    instr_q.push_back(ins);
  endtask

  // Operand words lean on the values where the flags and the signed compare
  // change behavior; the rest are fully random.
  function automatic logic [WordW-1:0] pick_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return WordOnes;
      2: return WordMaxPos;
      3: return WordSign;
      4: return 36'd1;
      5: return WordSign + WordW'($urandom_range(0, 3));
      6: return WordW'($urandom_range(0, 7));
      default: return r[WordW-1:0];
    endcase
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("Mismatch on %s: expected %0h, got %0h", field, want, got);
    end
  endtask

  // Neither side idles during the steady window or while the receiver is
  // holding off on purpose.
  assign steady = (issued_count >= SteadyFrom && issued_count < SteadyTo) || hold_left > 0;

  // Sender. An item is taken at an edge where valid is high and stall low;
  // its expected outcome is worked out right then. A stalled item is held
  // unchanged, and valid is raised from the steady window or a random roll, never from stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        outcome_q.push_back(execute_instr(in_item_i));
        issued_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (instr_q.size() > 0 && (steady || $urandom_range(0, 99) >= IdlePercent)) begin
          in_item_i <= instr_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each result is checked against the oldest outstanding outcome.
  // Once, after a few hundred items, the receiver stalls for a long stretch
  // so the pipeline fills and the unit has to stall its own input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("Unexpected result %0h with nothing outstanding", out_item_o);
        end else begin
          out_item_t want;
          want = outcome_q.pop_front();
          check_field("result_word", 64'(want.result_word), 64'(out_item_o.result_word));
          check_field("write_ac", 64'(want.write_ac), 64'(out_item_o.write_ac));
          check_field("write_mem", 64'(want.write_mem), 64'(out_item_o.write_mem));
          check_field("pc_action", 64'(want.pc_action), 64'(out_item_o.pc_action));
          check_field("next_pc", 64'(want.next_pc), 64'(out_item_o.next_pc));
          check_field("flags_set", 64'(want.flags_set), 64'(out_item_o.flags_set));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && issued_count >= HoldStartAt) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(0, 99) < IdlePercent);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [2:0] mode;
    logic [AddrW-1:0] ea;
    logic [AddrW-1:0] pc;
    logic [WordW-1:0] acw;
    logic [WordW-1:0] memw;
    logic [3:0] acn;
    int total_items;

    // Directed part. CAI against an immediate with the top address bit set:
    // it stays positive, and the skips land on both sides of the PC wrap.
    queue_instr(MODE_CAI, COND_L, 4'd1, '0, '0, 18'h3ffff, 18'h3ffff);
    queue_instr(MODE_CAI, COND_E, 4'd2, 36'h3ffff, WordOnes, 18'h3ffff, 18'h3fffe);
    queue_instr(MODE_CAI, COND_G, 4'd3, WordSign | 36'h3ffff, '0, 18'h3ffff, 18'h00010);
    queue_instr(MODE_CAI, COND_ALWAYS, 4'd0, WordOnes, '0, '0, 18'h3fffd);
    // CAM with the most negative and most positive words.
    queue_instr(MODE_CAM, COND_LE, 4'd4, WordSign, WordMaxPos, 18'h00100, 18'h00200);
    queue_instr(MODE_CAM, COND_GE, 4'd5, WordOnes, WordOnes, 18'h00101, 18'h00201);
    queue_instr(MODE_CAM, COND_N, 4'd6, '0, WordOnes, 18'h00102, 18'h00202);
    // Plain jumps: never, always to the top address, and on a negative AC.
    queue_instr(MODE_JUMP, COND_NEVER, 4'd7, '0, '0, 18'h12345, 18'h00300);
    queue_instr(MODE_JUMP, COND_ALWAYS, 4'd8, WordMaxPos, '0, 18'h3ffff, 18'h00301);
    queue_instr(MODE_JUMP, COND_L, 4'd9, WordOnes, '0, 18'h00000, 18'h00302);
    // SKIP with AC zero (no AC write) and with the top AC number.
    queue_instr(MODE_SKIP, COND_E, 4'd0, WordOnes, '0, 18'h00400, 18'h3ffff);
    queue_instr(MODE_SKIP, COND_G, 4'd15, '0, WordMaxPos, 18'h00401, 18'h00500);
    // Increments through overflow, through all-ones, and from zero.
    queue_instr(MODE_AOJ, COND_L, 4'd1, WordMaxPos, '0, 18'h20000, 18'h00600);
    queue_instr(MODE_AOJ, COND_E, 4'd2, WordOnes, '0, 18'h20001, 18'h00601);
    queue_instr(MODE_AOJ, COND_GE, 4'd3, '0, '0, 18'h20002, 18'h00602);
    queue_instr(MODE_AOS, COND_G, 4'd0, '0, WordMaxPos, 18'h20003, 18'h00603);
    queue_instr(MODE_AOS, COND_N, 4'd5, '0, WordOnes, 18'h20004, 18'h3fffe);
    // Decrements through the most negative word, from zero and from one.
    queue_instr(MODE_SOJ, COND_ALWAYS, 4'd6, WordSign, '0, 18'h30000, 18'h00700);
    queue_instr(MODE_SOJ, COND_L, 4'd7, '0, '0, 18'h30001, 18'h00701);
    queue_instr(MODE_SOJ, COND_E, 4'd8, 36'd1, '0, 18'h30002, 18'h00702);
    queue_instr(MODE_SOS, COND_LE, 4'd0, '0, WordSign, 18'h30003, 18'h00703);
    queue_instr(MODE_SOS, COND_GE, 4'd9, '0, '0, 18'h30004, 18'h00704);
    queue_instr(MODE_SOS, COND_NEVER, 4'd10, '0, 36'd5, 18'h30005, 18'h00705);

    // Random part. Equal operands are made often enough to exercise E, LE
    // and GE, and the PC is pushed to the top of memory now and then.
    for (int i = 0; i < RandomInstrs; i++) begin
      mode = 3'($urandom_range(0, 7));
      acn = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      acw = pick_word();
      memw = pick_word();
      ea = 18'($urandom_range(0, 18'h3ffff));
      pc = ($urandom_range(0, 15) == 0) ? 18'h3fffc + 18'($urandom_range(0, 3))
                                        : 18'($urandom_range(0, 18'h3ffff));
      if ($urandom_range(0, 3) == 0)
        memw = acw;
      if (mode == MODE_CAI && $urandom_range(0, 3) == 0)
        acw = {{(WordW - AddrW){1'b0}}, ea};
      queue_instr(mode, 3'($urandom_range(0, 7)), acn, acw, memw, ea, pc);
    end
    total_items = instr_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every instruction accepted and every outcome returned, then a further wait so that
    // a stray extra result from the three-stage pipe is caught.
    while (issued_count < total_items || outcome_q.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (error_count == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
